@@ rtl/tcm_pkg.sv @@
// shared types and constants for the transport and metronome block
package tcm_pkg;

    localparam int POS_W       = 48;
    localparam int FPB_W       = 48;
    localparam int CLICK_AW    = 11;
    localparam int CLICK_DEPTH = 1 << CLICK_AW;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int CLEN_W      = 12;
    localparam int BPB_W       = 8;
    localparam int CFG_IW      = 3;
    localparam int DIV_STEPS   = 64;
    localparam int DIV_CW      = 6;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int Z_W         = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SH    = 27;

    localparam logic [RECIP_W-1:0] RECIP5    = 25'd26843546;
    localparam logic [Z_W-1:0]     Z_OFFSET  = 24'd10485760;
    localparam logic [FPB_W-1:0]   FPB_MIN   = 48'd65536;
    localparam logic [BPB_W-1:0]   BPB_DFLT  = 8'd4;

    localparam logic [FPB_W-1:0] FPB_RST   = 48'd94371840;
    localparam logic [BPB_W-1:0] BPB_RST   = 8'd4;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_PLAY   = 3'd1,
        OP_STOP   = 3'd2,
        OP_REC    = 3'd3,
        OP_RECOFF = 3'd4,
        OP_COUNT  = 3'd5,
        OP_LOCATE = 3'd6,
        OP_CLICK  = 3'd7
    } opcode_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FPB   = 3'd0,
        CFG_BPB   = 3'd1,
        CFG_CLEN  = 3'd2,
        CFG_GAIN  = 3'd3,
        CFG_MET   = 3'd4,
        CFG_ROUTE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [FPB_W-1:0] rem;
        logic [BPB_W-1:0] qmod;
    } div_res_t;

endpackage

@@ rtl/tcm_div.sv @@
// bit-serial divider giving remainder and quotient modulo beats per bar
module tcm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tcm_pkg::POS_W-1:0] dividend,
    input  logic [tcm_pkg::FPB_W-1:0] divisor,
    input  logic [tcm_pkg::BPB_W-1:0] modulus,
    output logic                      done,
    output tcm_pkg::div_res_t         res
);
    import tcm_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CW-1:0]       cnt_reg, cnt_next;
    logic [DIV_STEPS-1:0]    shift_reg, shift_next;
    logic [FPB_W-1:0]        rem_reg, rem_next;
    logic [BPB_W-1:0]        qmod_reg, qmod_next;
    logic [FPB_W:0]          trial;
    logic                    qbit;
    logic [BPB_W:0]          qtrial;

    always_comb
    begin
        trial      = {rem_reg, shift_reg[DIV_STEPS-1]};
        qbit       = (trial >= {1'b0, divisor});
        qtrial     = {qmod_reg, qbit};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        qmod_next  = qmod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = {dividend, {(DIV_STEPS-POS_W){1'b0}}};
            rem_next   = '0;
            qmod_next  = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[DIV_STEPS-2:0], 1'b0};
            rem_next   = qbit ? FPB_W'(trial - {1'b0, divisor}) : trial[FPB_W-1:0];
            qmod_next  = (qtrial >= {1'b0, modulus}) ? BPB_W'(qtrial - {1'b0, modulus})
                                                     : qtrial[BPB_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        qmod_reg  <= qmod_next;
    end

    assign done     = done_reg;
    assign res.rem  = rem_reg;
    assign res.qmod = qmod_reg;

endmodule

@@ rtl/tcm_click_ram.sv @@
// click sample table, one write and one registered read port
module tcm_click_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic [tcm_pkg::CLICK_AW-1:0]        waddr,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0] wdata,
    input  logic                                re,
    input  logic [tcm_pkg::CLICK_AW-1:0]        raddr,
    output logic signed [tcm_pkg::SAMPLE_W-1:0] rdata
);
    import tcm_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [CLICK_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/transport_countin_metronome.sv @@
// transport and metronome top level with count-in and click generation
// non-click requests: result registered in the cycle after acceptance
// click ticks: the 64-step serial beat divider, then table read, gain multiply, scale and
// saturate stages (multiply and scale are skipped when the offset misses the table)
// one request in flight at a time; next accepted once the result slot is free
// asynchronous active-low reset clears transport state and config to defaults
module transport_countin_metronome (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          opcode,
    input  logic [7:0]                          beat_count,
    input  logic                                record_after,
    input  logic signed [tcm_pkg::POS_W-1:0]    new_position,
    input  logic [tcm_pkg::CLICK_AW-1:0]        click_index,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0] click_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tcm_pkg::SAMPLE_W-1:0] metronome_out,
    output logic signed [tcm_pkg::SAMPLE_W-1:0] main_out,
    output logic                                playing,
    output logic                                recording,
    output logic                                counting_in,
    output logic signed [tcm_pkg::POS_W-1:0]    play_position,
    output logic                                countin_accepted,
    input  logic                                cfg_we,
    input  logic [tcm_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [tcm_pkg::FPB_W-1:0]           cfg_data
);
    import tcm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RAM  = 5'b00100,
        S_SCL  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t st_reg, st_next;

    logic [FPB_W-1:0]  fpb_reg;
    logic [BPB_W-1:0]  bpb_reg;
    logic [CLEN_W-1:0] clen_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              met_reg, route_reg;

    logic              play_reg, play_next;
    logic              rec_reg, rec_next;
    logic              cin_reg, cin_next;
    logic              cpend_reg, cpend_next;
    logic [POS_W-1:0]  head_reg, head_next;
    logic [POS_W-1:0]  cpos_reg, cpos_next;
    logic [POS_W-1:0]  clen_cnt_reg, clen_cnt_next;

    logic              ov_reg, ov_next;
    logic signed [SAMPLE_W-1:0] omet_reg, omet_next;
    logic signed [SAMPLE_W-1:0] omain_reg, omain_next;
    logic              oplay_reg, oplay_next;
    logic              orec_reg, orec_next;
    logic              ocin_reg, ocin_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic              oacc_reg, oacc_next;

    logic                       nz_reg, nz_next;
    logic                       down_reg, down_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [SAMPLE_W+9:0] dn_reg, dn_next;
    logic [Z_W+RECIP_W-1:0]     m5_reg, m5_next;

    logic              accept, slot_free;
    logic              div_start, div_done;
    div_res_t          div_res;
    logic [POS_W-1:0]  div_a;
    logic [BPB_W-1:0]  bpb_eff;
    logic [FPB_W+8:0]  len_full;
    logic [POS_W-1:0]  len;
    logic              preroll, click_go, neg;
    logic [POS_W-1:0]  click_a;
    logic [32:0]       off;
    logic              off_ok;
    logic              ram_re;
    logic signed [SAMPLE_W-1:0] ram_rdata;
    logic signed [PROD_W+3:0]   p9;
    logic signed [PROD_W+3:0]   y_full;
    logic [Z_W-1:0]    z;
    logic signed [SAMPLE_W+9:0] rsel;
    logic signed [SAMPLE_W-1:0] rsat;
    logic [FPB_W:0]    rem_add;

    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (st_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign bpb_eff   = (bpb_reg == '0) ? BPB_DFLT : bpb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpb_reg   <= FPB_RST;
            bpb_reg   <= BPB_RST;
            clen_reg  <= '0;
            gain_reg  <= GAIN_RST;
            met_reg   <= 1'b0;
            route_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FPB:   fpb_reg   <= cfg_data;
                CFG_BPB:   bpb_reg   <= cfg_data[BPB_W-1:0];
                CFG_CLEN:  clen_reg  <= cfg_data[CLEN_W-1:0];
                CFG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_MET:   met_reg   <= cfg_data[0];
                CFG_ROUTE: route_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    tcm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (fpb_reg),
        .modulus  (bpb_eff),
        .done     (div_done),
        .res      (div_res)
    );

    assign rem_add = {1'b0, div_res.rem} + (FPB_W+1)'(32767);
    assign off     = (div_res.rem < FPB_W'(32768)) ? 33'd0 : rem_add[FPB_W:16];
    assign off_ok  = (off[32:CLICK_AW] == '0) &&
                     ({1'b0, off[CLICK_AW-1:0]} < clen_reg);
    assign ram_re  = (st_reg == S_DIV) && div_done;

    tcm_click_ram u_ram (
        .clk   (clk),
        .we    (accept && (opcode == OP_CLICK)),
        .waddr (click_index),
        .wdata (click_value),
        .re    (ram_re),
        .raddr (off[CLICK_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign len_full = ({9'd0, fpb_reg} * {{(FPB_W+1){1'b0}}, beat_count})
                      + (FPB_W+9)'(32768);
    assign len      = POS_W'(len_full[FPB_W+8:16]);

    assign p9     = ((PROD_W+4)'(prod_reg) <<< 3) + (PROD_W+4)'(prod_reg) + (PROD_W+4)'(40960);
    assign y_full = p9 >>> 14;
    assign z      = Z_W'(y_full) + Z_OFFSET;

    assign rsel = down_reg ? dn_reg
                           : (SAMPLE_W+10)'(m5_reg[Z_W+RECIP_W-1:RECIP_SH]) - (SAMPLE_W+10)'(2097152);
    assign rsat = !nz_reg ? '0
                : (rsel > (SAMPLE_W+10)'(32767))  ? SAMPLE_W'(32767)
                : (rsel < -(SAMPLE_W+10)'(32768)) ? SAMPLE_W'(-32768)
                : SAMPLE_W'(rsel);

    always_comb
    begin
        st_next       = st_reg;
        play_next     = play_reg;
        rec_next      = rec_reg;
        cin_next      = cin_reg;
        cpend_next    = cpend_reg;
        head_next     = head_reg;
        cpos_next     = cpos_reg;
        clen_cnt_next = clen_cnt_reg;
        ov_next       = ov_reg && !out_ready;
        omet_next     = omet_reg;
        omain_next    = omain_reg;
        oplay_next    = oplay_reg;
        orec_next     = orec_reg;
        ocin_next     = ocin_reg;
        opos_next     = opos_reg;
        oacc_next     = oacc_reg;
        nz_next       = nz_reg;
        down_next     = down_reg;
        prod_next     = prod_reg;
        dn_next       = dn_reg;
        m5_next       = m5_reg;
        div_start     = 1'b0;
        div_a         = '0;
        preroll       = 1'b0;
        click_go      = 1'b0;
        neg           = 1'b0;
        click_a       = head_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    oacc_next = 1'b0;
                    unique case (opcode_t'(opcode))
                        OP_TICK:
                        begin
                            if (cin_reg)
                            begin
                                if (cpos_reg >= clen_cnt_reg)
                                begin
                                    cin_next  = 1'b0;
                                    play_next = 1'b1;
                                    if (cpend_reg)
                                    begin
                                        rec_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    preroll   = 1'b1;
                                    click_a   = cpos_reg;
                                    cpos_next = cpos_reg + 1'b1;
                                end
                            end
                            if (play_next)
                            begin
                                head_next = head_reg + 1'b1;
                            end
                            neg      = click_a[POS_W-1];
                            click_go = ((play_next && met_reg) || preroll) &&
                                       (clen_reg != '0) && (fpb_reg > FPB_MIN) && !neg;
                        end
                        OP_PLAY:
                        begin
                            play_next = 1'b1;
                        end
                        OP_STOP:
                        begin
                            play_next  = 1'b0;
                            cin_next   = 1'b0;
                            cpend_next = 1'b0;
                        end
                        OP_REC:
                        begin
                            rec_next  = 1'b1;
                            play_next = 1'b1;
                        end
                        OP_RECOFF:
                        begin
                            rec_next   = 1'b0;
                            cin_next   = 1'b0;
                            cpend_next = 1'b0;
                        end
                        OP_COUNT:
                        begin
                            if (beat_count != '0)
                            begin
                                if (cin_reg)
                                begin
                                    oacc_next = 1'b1;
                                end
                                else if ((fpb_reg != '0) && (len != '0))
                                begin
                                    cpos_next     = '0;
                                    clen_cnt_next = len;
                                    cpend_next    = record_after;
                                    cin_next      = 1'b1;
                                    oacc_next     = 1'b1;
                                end
                            end
                        end
                        OP_LOCATE:
                        begin
                            play_next  = 1'b0;
                            rec_next   = 1'b0;
                            cin_next   = 1'b0;
                            cpend_next = 1'b0;
                            head_next  = new_position;
                        end
                        OP_CLICK:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                    oplay_next = play_next;
                    orec_next  = rec_next;
                    ocin_next  = cin_next;
                    opos_next  = head_next;
                    if (click_go)
                    begin
                        div_start = 1'b1;
                        div_a     = click_a;
                        st_next   = S_DIV;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        omet_next  = '0;
                        omain_next = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    down_next = (div_res.qmod == '0);
                    nz_next   = off_ok;
                    st_next   = off_ok ? S_RAM : S_FIN;
                end
            end
            S_RAM:
            begin
                prod_next = PROD_W'(ram_rdata) * $signed({1'b0, gain_reg});
                st_next   = S_SCL;
            end
            S_SCL:
            begin
                dn_next = (SAMPLE_W+10)'((prod_reg + PROD_W'(2048)) >>> 12);
                m5_next = (Z_W+RECIP_W)'(z) * (Z_W+RECIP_W)'(RECIP5);
                st_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    omet_next  = rsat;
                    omain_next = route_reg ? rsat : '0;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            play_reg     <= 1'b0;
            rec_reg      <= 1'b0;
            cin_reg      <= 1'b0;
            cpend_reg    <= 1'b0;
            head_reg     <= '0;
            cpos_reg     <= '0;
            clen_cnt_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            play_reg     <= play_next;
            rec_reg      <= rec_next;
            cin_reg      <= cin_next;
            cpend_reg    <= cpend_next;
            head_reg     <= head_next;
            cpos_reg     <= cpos_next;
            clen_cnt_reg <= clen_cnt_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        omet_reg  <= omet_next;
        omain_reg <= omain_next;
        oplay_reg <= oplay_next;
        orec_reg  <= orec_next;
        ocin_reg  <= ocin_next;
        opos_reg  <= opos_next;
        oacc_reg  <= oacc_next;
        nz_reg    <= nz_next;
        down_reg  <= down_next;
        prod_reg  <= prod_next;
        dn_reg    <= dn_next;
        m5_reg    <= m5_next;
    end

    assign out_valid        = ov_reg;
    assign metronome_out    = omet_reg;
    assign main_out         = omain_reg;
    assign playing          = oplay_reg;
    assign recording        = orec_reg;
    assign counting_in      = ocin_reg;
    assign play_position    = opos_reg;
    assign countin_accepted = oacc_reg;

    a_cin_len: assert property (@(posedge clk) disable iff (!rst_n)
        cin_reg |-> (clen_cnt_reg != '0))
        else $error("count-in active with zero length");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while a click is in progress");

    a_ram_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && off_ok) |=> (st_reg == S_RAM))
        else $error("table read not followed by multiply");

endmodule

@@ dv/tb_transport_countin_metronome.sv @@
// self-checking testbench for the transport and metronome block
module tb_transport_countin_metronome;
    import tcm_pkg::*;

    typedef struct {
        opcode_t         op;
        logic [7:0]      beats;
        logic            rec_after;
        logic [POS_W-1:0] pos;
        logic [10:0]     idx;
        logic [15:0]     val;
    } request_t;

    typedef struct {
        logic [15:0]      met;
        logic [15:0]      main;
        logic             play;
        logic             rec;
        logic             cin;
        logic [POS_W-1:0] pos;
        logic             acc;
    } frame_out_t;

    typedef struct {
        request_t   req;
        bit         typed;
        frame_out_t want;
    } stim_row_t;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_PER_PHASE = 200;
    localparam int NUM_PHASES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] opcode = '0;
    logic [7:0] beat_count = '0;
    logic record_after = 1'b0;
    logic signed [POS_W-1:0] new_position = '0;
    logic [CLICK_AW-1:0] click_index = '0;
    logic signed [SAMPLE_W-1:0] click_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] metronome_out;
    logic signed [SAMPLE_W-1:0] main_out;
    logic playing;
    logic recording;
    logic counting_in;
    logic signed [POS_W-1:0] play_position;
    logic countin_accepted;
    logic cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [FPB_W-1:0] cfg_data = '0;

    transport_countin_metronome dut (.*);

    always #4 clk = ~clk;

    // mirrored configuration
    logic [47:0] m_fpb;
    logic [7:0]  m_bpb;
    logic [11:0] m_clen;
    logic [15:0] m_gain;
    logic        m_met;
    logic        m_route;

    // mirrored transport state
    logic        play_f, rec_f, cin_act, cin_rec;
    logic [47:0] head, cin_pos, cin_len;
    logic signed [15:0] click_mem [CLICK_DEPTH];
    bit          written [CLICK_DEPTH];

    frame_out_t pending_frames[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    // beat number and in-beat offset of frame a
    function automatic void beat_split(input logic [47:0] a, output longint unsigned q,
                                       output longint unsigned off);
        longint unsigned num, den, rem;
        num = {a, 16'h0000};
        den = {16'h0000, m_fpb};
        q = num / den;
        rem = num % den;
        off = (rem < 32768) ? 0 : ((rem + 32767) >> 16);
    endfunction

    function automatic logic [15:0] click_sample(input logic [47:0] a);
        longint unsigned q, off, bpb;
        longint p, r;
        beat_split(a, q, off);
        if (off >= m_clen || off >= CLICK_DEPTH)
            return 16'h0000;
        bpb = (m_bpb != 0) ? m_bpb : 4;
        p = longint'(click_mem[off]) * longint'({1'b0, m_gain});
        if ((q % bpb) != 0)
            r = floor_div(18 * p + 81920, 163840);
        else
            r = floor_div(2 * p + 4096, 8192);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // table entry the next tick would read while still unwritten, else -1
    function automatic int unwritten_tick_read();
        bit pre, pl;
        logic [47:0] a;
        longint unsigned q, off;
        pre = cin_act && (cin_pos < cin_len);
        pl = play_f || (cin_act && !pre);
        a = pre ? cin_pos : head;
        if (((pl && m_met) || pre) && m_clen > 0 && m_fpb > 48'd65536 && !a[47]) begin
            beat_split(a, q, off);
            if (off < m_clen && off < CLICK_DEPTH && !written[off])
                return int'(off);
        end
        return -1;
    endfunction

    function automatic frame_out_t transport_step(input request_t c);
        frame_out_t r;
        bit preroll;
        logic [47:0] base, a;
        logic [15:0] click;
        longint unsigned len;
        logic acc;
        preroll = 0;
        base = '0;
        click = '0;
        acc = 1'b0;
        case (c.op)
            OP_TICK: begin
                if (cin_act) begin
                    if (cin_pos >= cin_len) begin
                        cin_act = 0;
                        play_f = 1;
                        if (cin_rec)
                            rec_f = 1;
                    end
                    else begin
                        preroll = 1;
                        base = cin_pos;
                        cin_pos = cin_pos + 1;
                    end
                end
                if (play_f)
                    head = head + 1;
                if (((play_f && m_met) || preroll) && m_clen > 0 && m_fpb > 48'd65536) begin
                    a = preroll ? base : head - 1;
                    if (!a[47])
                        click = click_sample(a);
                end
            end
            OP_PLAY: play_f = 1;
            OP_STOP: begin
                play_f = 0;
                cin_act = 0;
                cin_rec = 0;
            end
            OP_REC: begin
                rec_f = 1;
                play_f = 1;
            end
            OP_RECOFF: begin
                rec_f = 0;
                cin_act = 0;
                cin_rec = 0;
            end
            OP_COUNT: begin
                if (c.beats != 0) begin
                    if (cin_act)
                        acc = 1'b1;
                    else if (m_fpb != 0) begin
                        len = ({16'h0, m_fpb} * c.beats + 32768) >> 16;
                        if (len > 0) begin
                            cin_pos = '0;
                            cin_len = len[47:0];
                            cin_rec = c.rec_after;
                            cin_act = 1;
                            acc = 1'b1;
                        end
                    end
                end
            end
            OP_LOCATE: begin
                play_f = 0;
                rec_f = 0;
                cin_act = 0;
                cin_rec = 0;
                head = c.pos;
            end
            default: begin
                click_mem[c.idx] = c.val;
                written[c.idx] = 1;
            end
        endcase
        r.met = click;
        r.main = m_route ? click : 16'h0000;
        r.play = play_f;
        r.rec = rec_f;
        r.cin = cin_act;
        r.pos = head;
        r.acc = acc;
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FPB:   m_fpb = value;
            CFG_BPB:   m_bpb = value[7:0];
            CFG_CLEN:  m_clen = value[11:0];
            CFG_GAIN:  m_gain = value[15:0];
            CFG_MET:   m_met = value[0];
            default:   m_route = value[0];
        endcase
    endtask

    task automatic send_request(input request_t c, input bit typed, input frame_out_t want);
        frame_out_t got;
        in_valid <= 1'b1;
        opcode <= c.op;
        beat_count <= c.beats;
        record_after <= c.rec_after;
        new_position <= c.pos;
        click_index <= c.idx;
        click_value <= c.val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = transport_step(c);
        pending_frames.push_back(typed ? want : got);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic request_t random_request();
        request_t c;
        int pick;
        longint unsigned p;
        c.op = OP_TICK;
        c.beats = $urandom();
        c.rec_after = $urandom();
        c.pos = {$urandom(), $urandom()};
        c.idx = $urandom();
        c.val = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 55)
            c.op = OP_TICK;
        else if (pick < 62)
            c.op = OP_PLAY;
        else if (pick < 65)
            c.op = OP_STOP;
        else if (pick < 69)
            c.op = OP_REC;
        else if (pick < 72)
            c.op = OP_RECOFF;
        else if (pick < 80) begin
            c.op = OP_COUNT;
            if ($urandom_range(0, 9) < 7)
                c.beats = $urandom_range(1, 3);
        end
        else if (pick < 88) begin
            c.op = OP_LOCATE;
            // land near a beat start so clicks fall in the table window
            if ($urandom_range(0, 3) != 0) begin
                p = ({16'h0, m_fpb} * $urandom_range(0, 1000)) >> 16;
                c.pos = p[47:0] + $urandom_range(0, m_clen + 4);
            end
            else if ($urandom_range(0, 1) != 0)
                c.pos = -$urandom_range(1, 4);
        end
        else begin
            c.op = OP_CLICK;
            if (m_clen > 0 && $urandom_range(0, 1) != 0)
                c.idx = $urandom_range(0, (m_clen > 2048 ? 2048 : m_clen) - 1);
        end
        if (c.op == OP_TICK && unwritten_tick_read() >= 0) begin
            c.op = OP_CLICK;
            c.idx = unwritten_tick_read();
        end
        return c;
    endfunction

    function automatic logic [47:0] pick_fpb();
        case ($urandom_range(0, 7))
            0: return 48'd0;
            1: return 48'd65536;
            2: return 48'd65537;
            3: return 48'hFFFF_FFFF_FFFF;
            4: return 48'd327680;
            default: return $urandom_range(2, 40) * 65536 + $urandom_range(0, 65535);
        endcase
    endfunction

    // result checker
    always @(posedge clk) begin
        frame_out_t e;
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (out_valid && out_ready) begin
            if (pending_frames.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else begin
                e = pending_frames.pop_front();
                if (metronome_out !== e.met || main_out !== e.main || playing !== e.play ||
                    recording !== e.rec || counting_in !== e.cin ||
                    play_position !== e.pos || countin_accepted !== e.acc) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp met %h main %h pl %b rc %b ci %b pos %h acc %b, got met %h main %h pl %b rc %b ci %b pos %h acc %b",
                                 e.met, e.main, e.play, e.rec, e.cin, e.pos, e.acc,
                                 metronome_out, main_out, playing, recording,
                                 counting_in, play_position, countin_accepted);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic stim_row_t row(input opcode_t op, input logic [7:0] beats,
                                      input logic rec_after, input logic [47:0] pos,
                                      input logic [10:0] idx, input logic [15:0] val);
        stim_row_t r;
        r.req = '{op, beats, rec_after, pos, idx, val};
        r.typed = 0;
        r.want = '{16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 48'h0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t r, input logic play,
                                            input logic rec, input logic [47:0] pos,
                                            input logic acc);
        r.typed = 1;
        r.want = '{16'h0, 16'h0, play, rec, 1'b0, pos, acc};
        return r;
    endfunction

    initial begin
        stim_row_t directed[$];
        request_t c;
        frame_out_t none;
        int k;
        m_fpb = FPB_RST;
        m_bpb = BPB_RST;
        m_clen = '0;
        m_gain = GAIN_RST;
        m_met = 0;
        m_route = 0;
        play_f = 0;
        rec_f = 0;
        cin_act = 0;
        cin_rec = 0;
        head = '0;
        cin_pos = '0;
        cin_len = '0;
        foreach (written[i])
            written[i] = 0;
        none = '{16'h0, 16'h0, 1'b0, 1'b0, 1'b0, 48'h0, 1'b0};

        directed.push_back(typed_row(row(OP_TICK, 8'hFF, 1, 48'hFFFF_FFFF_FFFF, 11'h7FF,
                                         16'hFFFF), 0, 0, 48'h0, 0));
        directed.push_back(typed_row(row(OP_COUNT, 8'd0, 1, '0, '0, '0), 0, 0, 48'h0, 0));
        directed.push_back(row(OP_CLICK, 0, 0, '0, 11'd0, 16'h8000));
        directed.push_back(row(OP_CLICK, 0, 0, '0, 11'd1, 16'h7FFF));
        directed.push_back(row(OP_CLICK, 0, 0, '0, 11'd2047, 16'h7FFF));
        directed.push_back(row(OP_CLICK, 0, 0, '0, 11'd2, 16'h0001));
        directed.push_back(typed_row(row(OP_PLAY, 0, 0, '0, '0, '0), 1, 0, 48'h0, 0));
        directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_REC, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_RECOFF, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_STOP, 0, 0, '0, '0, '0));
        directed.push_back(typed_row(row(OP_LOCATE, 0, 0, 48'h7FFF_FFFF_FFFF, '0, '0),
                                     0, 0, 48'h7FFF_FFFF_FFFF, 0));
        directed.push_back(row(OP_PLAY, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(typed_row(row(OP_LOCATE, 0, 0, 48'h8000_0000_0000, '0, '0),
                                     0, 0, 48'h8000_0000_0000, 0));
        directed.push_back(row(OP_REC, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_LOCATE, 0, 0, 48'h0, '0, '0));
        directed.push_back(row(OP_COUNT, 8'd1, 1, '0, '0, '0));
        directed.push_back(row(OP_COUNT, 8'd255, 0, '0, '0, '0));
        for (k = 0; k < 3; k++)
            directed.push_back(row(OP_TICK, 0, 0, '0, '0, '0));
        directed.push_back(row(OP_STOP, 0, 0, '0, '0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // short count-in with a three-sample table for the directed part
        write_reg(CFG_FPB, 48'd196608);
        write_reg(CFG_CLEN, 48'd3);
        write_reg(CFG_MET, 48'd1);
        write_reg(CFG_ROUTE, 48'd1);
        foreach (directed[i])
            send_request(directed[i].req, directed[i].typed, directed[i].want);
        for (k = 0; k < 6; k++)
            send_request(row(OP_TICK, 0, 0, '0, '0, '0).req, 0, none);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            in_valid <= 1'b0;
            while (pending_frames.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 80; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 80; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 0) begin
                write_reg(CFG_FPB, 48'hFFFF_FFFF_FFFF);
                write_reg(CFG_BPB, 48'd255);
                write_reg(CFG_CLEN, 48'd2048);
                write_reg(CFG_GAIN, 48'd65535);
            end
            else if (ph == 1) begin
                write_reg(CFG_FPB, 48'd0);
                write_reg(CFG_BPB, 48'd0);
                write_reg(CFG_CLEN, 48'd0);
                write_reg(CFG_GAIN, 48'd0);
            end
            else begin
                write_reg(CFG_FPB, pick_fpb());
                write_reg(CFG_BPB, $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 5));
                write_reg(CFG_CLEN, $urandom_range(0, 3) == 0 ? 2048 : $urandom_range(1, 40));
                write_reg(CFG_GAIN, $urandom_range(0, 65535));
            end
            write_reg(CFG_MET, $urandom_range(0, 3) != 0);
            write_reg(CFG_ROUTE, $urandom_range(0, 1));
            for (k = 0; k < RAND_PER_PHASE; k++) begin
                c = random_request();
                send_request(c, 0, none);
            end
        end
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcm_pkg.sv
rtl/tcm_div.sv
rtl/tcm_click_ram.sv
rtl/transport_countin_metronome.sv
dv/tb_transport_countin_metronome.sv
